>>> hdl/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned HUE_W       = 15;
    localparam int unsigned SAT_W       = 16;
    localparam int unsigned T_W         = 11;

    // Divider geometry: numerator, divisor, reciprocal widths and stage count.
    localparam int unsigned DIV_NW      = 24;
    localparam int unsigned DIV_DW      = 8;
    localparam int unsigned DIV_RW      = 25;
    localparam int unsigned DIV_DEPTH   = 256;
    localparam int unsigned DIV_LAT     = 4;

    localparam logic [11:0]       HUE_UNITS_PER_SECTOR = 12'd3840;
    localparam logic [DIV_NW-1:0] HUE_FULL_CIRCLE      = 24'd23040;
    localparam logic [DIV_NW-1:0] SAT_MAX              = 24'd65535;

    // Stage-one word: channel statistics and the unscaled sector position.
    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] delta;
        logic [T_W-1:0]    t;
        logic              undef;
    } rhc_front_t;

endpackage

`default_nettype wire

>>> hdl/rhc_front.sv
// First pipeline stage: max, min, delta and the sector position of the hue.
// Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_front
    import rhc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              valid,
    input  wire logic [CHAN_W-1:0] red,
    input  wire logic [CHAN_W-1:0] green,
    input  wire logic [CHAN_W-1:0] blue,
    output rhc_front_t             front
);

    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W-1:0] delta;
    logic signed [11:0] t_s;
    logic signed [11:0] six_delta;
    rhc_front_t front_reg;
    rhc_front_t front_next;

    always_comb
    begin
        mx = (red > green) ? red : green;
        mx = (blue > mx) ? blue : mx;
        mn = (red < green) ? red : green;
        mn = (blue < mn) ? blue : mn;
        delta = mx - mn;
        six_delta = $signed({2'b00, delta, 2'b00}) + $signed({3'b000, delta, 1'b0});

        // Red wins ties over green, and green over blue.
        priority if (red == mx)
        begin
            t_s = $signed({4'b0000, green}) - $signed({4'b0000, blue});
        end
        else if (green == mx)
        begin
            t_s = $signed({3'b000, delta, 1'b0}) + $signed({4'b0000, blue})
                - $signed({4'b0000, red});
        end
        else
        begin
            t_s = $signed({2'b00, delta, 2'b00}) + $signed({4'b0000, red})
                - $signed({4'b0000, green});
        end
        if (t_s < 0)
        begin
            t_s = t_s + six_delta;
        end

        front_next.valid = valid;
        front_next.mx    = mx;
        front_next.delta = delta;
        front_next.t     = T_W'(t_s);
        front_next.undef = (delta == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else if (en)
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

>>> hdl/rhc_div.sv
// Four-stage pipelined divider: reciprocal lookup, multiply, back-multiply,
// and a single compare-and-add correction. Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_div
    import rhc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [DIV_NW-1:0] num,
    input  wire logic [DIV_DW-1:0] den,
    output logic      [DIV_NW-1:0] quot
);

    logic [DIV_RW-1:0] recip_tab [DIV_DEPTH];

    logic [DIV_NW-1:0]        a_num_reg;
    logic [DIV_DW-1:0]        a_den_reg;
    logic [DIV_RW-1:0]        a_recip_reg;
    logic [DIV_NW+DIV_RW-1:0] a_prod;

    logic [DIV_NW-1:0] b_q0_reg;
    logic [DIV_NW-1:0] b_num_reg;
    logic [DIV_DW-1:0] b_den_reg;
    logic [DIV_NW+DIV_DW-1:0] b_prod;

    logic [DIV_NW-1:0] c_q0_reg;
    logic [DIV_NW-1:0] c_num_reg;
    logic [DIV_DW-1:0] c_den_reg;
    logic [DIV_NW-1:0] c_qd_reg;
    logic [DIV_NW-1:0] c_rem;

    logic [DIV_NW-1:0] quot_reg;
    logic [DIV_NW-1:0] quot_next;

    // Table entries are floor(2^NW / d); the estimate is then low by at most one.
    assign recip_tab[0] = '0;
    for (genvar idx = 1; idx < DIV_DEPTH; idx++)
    begin : g_recip
        localparam longint unsigned DIVISOR = idx;
        localparam logic [DIV_RW-1:0] RECIP = DIV_RW'((64'd1 << DIV_NW) / DIVISOR);
        assign recip_tab[idx] = RECIP;
    end

    assign a_prod = DIV_NW'(0) + a_num_reg * a_recip_reg;
    assign b_prod = b_q0_reg * b_den_reg;
    assign c_rem  = c_num_reg - c_qd_reg;

    always_comb
    begin
        quot_next = c_q0_reg;
        if (c_rem >= DIV_NW'(c_den_reg))
        begin
            quot_next = c_q0_reg + DIV_NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_num_reg   <= num;
            a_den_reg   <= den;
            a_recip_reg <= recip_tab[den];

            b_q0_reg    <= DIV_NW'(a_prod >> DIV_NW);
            b_num_reg   <= a_num_reg;
            b_den_reg   <= a_den_reg;

            c_q0_reg    <= b_q0_reg;
            c_num_reg   <= b_num_reg;
            c_den_reg   <= b_den_reg;
            c_qd_reg    <= DIV_NW'(b_prod);

            quot_reg    <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

>>> hdl/rgb_to_hsv_converter_core.sv
// RGB to HSV converter, one pixel word per clock.
// An accepted pixel passes the first stage, the dividers and the output register to become its HSV word.
// Throughput: one word per cycle; the whole pipeline holds while the output is stalled.
// Depth is set by the two reciprocal dividers (hue and saturation), four stages each.
// Reset clears all valid bits and the first stage; later data registers are not reset.
// Depends on rhc_pkg, rhc_front and rhc_div.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter_core
    import rhc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pix_valid,
    output logic                   pix_ready,
    input  wire logic [CHAN_W-1:0] red,
    input  wire logic [CHAN_W-1:0] green,
    input  wire logic [CHAN_W-1:0] blue,
    output logic                   hsv_valid,
    input  wire logic              hsv_ready,
    output logic [HUE_W-1:0]       hue,
    output logic [SAT_W-1:0]       saturation,
    output logic [CHAN_W-1:0]      value,
    output logic                   hue_undefined
);

    logic       adv;
    rhc_front_t front;

    logic [DIV_NW-1:0] hue_num;
    logic [DIV_NW-1:0] sat_num;
    logic [DIV_NW-1:0] hue_q;
    logic [DIV_NW-1:0] sat_q;

    logic              vld_reg   [DIV_LAT];
    logic [CHAN_W-1:0] mx_reg    [DIV_LAT];
    logic              undef_reg [DIV_LAT];

    logic              out_valid_reg;
    logic [HUE_W-1:0]  hue_reg;
    logic [HUE_W-1:0]  hue_next;
    logic [SAT_W-1:0]  sat_reg;
    logic [SAT_W-1:0]  sat_next;
    logic [CHAN_W-1:0] value_reg;
    logic              undef_out_reg;

    // The pipeline moves as one; it only holds while a finished word is refused.
    assign adv       = !out_valid_reg || hsv_ready;
    assign pix_ready = adv;

    rhc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .valid (pix_valid),
        .red   (red),
        .green (green),
        .blue  (blue),
        .front (front)
    );

    // Both numerators carry half the divisor so the quotient rounds to nearest.
    assign hue_num = DIV_NW'(front.t * HUE_UNITS_PER_SECTOR) + DIV_NW'(front.delta >> 1);
    assign sat_num = {front.delta, 16'd0} + DIV_NW'(front.mx >> 1);

    rhc_div u_hue_div (
        .clk  (clk),
        .en   (adv),
        .num  (hue_num),
        .den  (front.delta),
        .quot (hue_q)
    );

    rhc_div u_sat_div (
        .clk  (clk),
        .en   (adv),
        .num  (sat_num),
        .den  (front.mx),
        .quot (sat_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= front.valid;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg[0]    <= front.mx;
            undef_reg[0] <= front.undef;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                mx_reg[i]    <= mx_reg[i-1];
                undef_reg[i] <= undef_reg[i-1];
            end
        end
    end

    always_comb
    begin
        hue_next = HUE_W'(hue_q);
        if (hue_q >= HUE_FULL_CIRCLE)
        begin
            hue_next = HUE_W'(hue_q - HUE_FULL_CIRCLE);
        end
        sat_next = SAT_W'(sat_q);
        if (sat_q > SAT_MAX)
        begin
            sat_next = SAT_W'(SAT_MAX);
        end
        // Grey and black pixels have no hue; both fields are forced to zero.
        if (undef_reg[DIV_LAT-1])
        begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hue_reg       <= hue_next;
            sat_reg       <= sat_next;
            value_reg     <= mx_reg[DIV_LAT-1];
            undef_out_reg <= undef_reg[DIV_LAT-1];
        end
    end

    assign hsv_valid     = out_valid_reg;
    assign hue           = hue_reg;
    assign saturation    = sat_reg;
    assign value         = value_reg;
    assign hue_undefined = undef_out_reg;

endmodule

`default_nettype wire

>>> hdl/rhc_checker.sv
// Port-level checks for rgb_to_hsv_converter_core, bound to the top level.
// Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_checker
    import rhc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              hsv_valid,
    input wire logic              hsv_ready,
    input wire logic [HUE_W-1:0]  hue,
    input wire logic [SAT_W-1:0]  saturation,
    input wire logic [CHAN_W-1:0] value,
    input wire logic              hue_undefined
);

    // A refused word must hold until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && !hsv_ready |=> hsv_valid && $stable(hue) && $stable(saturation)
            && $stable(value) && $stable(hue_undefined))
        else $error("output word changed while stalled");

    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hue_undefined |-> hue == '0 && saturation == '0)
        else $error("undefined hue with nonzero hue or saturation");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && value == '0 |-> hue_undefined)
        else $error("black pixel not flagged");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> hue < HUE_W'(HUE_FULL_CIRCLE))
        else $error("hue outside a full circle");

    // A colored pixel has delta at least one and value at most 255.
    a_sat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && !hue_undefined |-> saturation != '0)
        else $error("colored pixel with zero saturation");

endmodule

bind rgb_to_hsv_converter_core rhc_checker u_rhc_checker (.*);

`default_nettype wire
